### src/ssb_pkg.sv
// ssb_pkg: shared types and constants of the scaled sprite blit address generator.
// Used by every module under src; depends on nothing.
`default_nettype none

package ssb_pkg;

    // Defaults for the top-level parameters
    localparam int PIXEL_BYTES_DEF = 3;
    localparam int MAX_SCALE_DEF   = 8;

    // Configuration port geometry
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Shared multiply-add unit widths
    localparam int MAC_A_W = 16;
    localparam int MAC_B_W = 15;
    localparam int MAC_Y_W = 26;

    // Register reset values
    localparam logic [12:0] SCREEN_WIDTH_RST  = 13'd1024;
    localparam logic [12:0] SCREEN_HEIGHT_RST = 13'd768;
    localparam logic [14:0] ROW_PITCH_RST     = 15'd3072;
    localparam logic [3:0]  SCALE_FACTOR_RST  = 4'd1;

    typedef enum logic [2:0] {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_ROW_PITCH     = 3'd2,
        REG_DEST_X        = 3'd3,
        REG_DEST_Y        = 3'd4,
        REG_IMAGE_WIDTH   = 3'd5,
        REG_IMAGE_HEIGHT  = 3'd6,
        REG_SCALE_FACTOR  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [12:0]        screen_width;
        logic [12:0]        screen_height;
        logic [14:0]        row_pitch;
        logic signed [12:0] dest_x;
        logic signed [12:0] dest_y;
        logic [12:0]        image_width;
        logic [12:0]        image_height;
        logic [3:0]         scale_factor;
    } ssb_cfg_t;

    typedef struct packed {
        logic [11:0] src_col;
        logic [11:0] src_row;
        logic [31:0] pixel_color;
    } ssb_in_t;

    typedef struct packed {
        logic [25:0] byte_offset;
        logic [23:0] write_color;
        logic        last_write;
    } ssb_out_t;

endpackage

`default_nettype wire

### src/scaled_sprite_blit_address_gen.sv
// scaled_sprite_blit_address_gen: top level, sequencer around one shared multiply-add unit.
// Depends on ssb_pkg, ssb_cfg and ssb_mac.
//
// Usage:
//   Configure through the APB-style port while the block is idle; pready is always high.
//   Present a source pixel on pixel and raise start; the transfer happens on an edge
//   where start is high and busy is low. busy stays high until the item's last write
//   has been issued.
//   An item that fails the origin, source-range or transparency test is dropped at
//   accept and busy never rises. Otherwise the setup states XEDGE, YEDGE, XPOS, YPOS,
//   XOFF and BASE run the edge checks and compute the base offset, all through the one
//   multiply-add unit; a failed edge check returns to idle with no writes.
//   The write phase then issues one write per cycle, s*s writes at effective scale s,
//   row by row, each on result for one cycle marked by result_valid; last_write flags
//   the final one. The shared multiply-add unit also forms each next offset.
//   Results are registered: the first write shows in the cycle after the write phase
//   starts. The receiver cannot stall.
//   Reset clears the sequencer, the output strobe and the config registers to their defaults.
`default_nettype none

module scaled_sprite_blit_address_gen #(
    parameter int PIXEL_BYTES = ssb_pkg::PIXEL_BYTES_DEF,
    parameter int MAX_SCALE   = ssb_pkg::MAX_SCALE_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire ssb_pkg::ssb_in_t            pixel,
    output logic                             result_valid,
    output ssb_pkg::ssb_out_t                result,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ssb_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [ssb_pkg::DATA_W-1:0]  pwdata,
    output logic      [ssb_pkg::DATA_W-1:0]  prdata,
    output logic                             pready
);

    localparam int SCALE_W = (MAX_SCALE < 2) ? 1 : $clog2(MAX_SCALE + 1);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_XEDGE = 8'b0000_0010,
        ST_YEDGE = 8'b0000_0100,
        ST_XPOS  = 8'b0000_1000,
        ST_YPOS  = 8'b0001_0000,
        ST_XOFF  = 8'b0010_0000,
        ST_BASE  = 8'b0100_0000,
        ST_WRITE = 8'b1000_0000
    } state_t;

    ssb_pkg::ssb_cfg_t cfg;

    state_t             state_reg, state_next;
    logic [11:0]        col_reg, col_next;
    logic [11:0]        row_reg, row_next;
    logic [23:0]        color_reg, color_next;
    logic [25:0]        acc_reg, acc_next;
    logic [25:0]        off_reg, off_next;
    logic [25:0]        row_base_reg, row_base_next;
    logic [SCALE_W-1:0] sx_reg, sx_next;
    logic [SCALE_W-1:0] sy_reg, sy_next;
    logic               result_valid_reg, result_valid_next;
    ssb_pkg::ssb_out_t  result_reg, result_next;

    logic [SCALE_W-1:0] scale;
    logic [SCALE_W-1:0] scale_max;
    logic               accept;
    logic               item_ok;
    logic               row_end;
    logic               blk_end;

    logic [ssb_pkg::MAC_A_W-1:0] mac_a;
    logic [ssb_pkg::MAC_B_W-1:0] mac_b;
    logic [ssb_pkg::MAC_Y_W-1:0] mac_c;
    logic [ssb_pkg::MAC_Y_W-1:0] mac_y;

    ssb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ssb_mac u_mac (
        .a (mac_a),
        .b (mac_b),
        .c (mac_c),
        .y (mac_y)
    );

    // Effective scale: zero acts as one, saturate at MAX_SCALE
    always_comb
    begin
        if (cfg.scale_factor == 4'd0)
            scale = SCALE_W'(1);
        else if (cfg.scale_factor > 4'(MAX_SCALE))
            scale = SCALE_W'(MAX_SCALE);
        else
            scale = SCALE_W'(cfg.scale_factor);
    end

    assign scale_max = scale - SCALE_W'(1);
    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign row_end   = (sx_reg == scale_max);
    assign blk_end   = row_end && (sy_reg == scale_max);

    assign item_ok = !cfg.dest_x[12] && !cfg.dest_y[12]
                     && ({1'b0, pixel.src_col} < cfg.image_width)
                     && ({1'b0, pixel.src_row} < cfg.image_height)
                     && (pixel.pixel_color != 32'd0);

    // Operand selection for the shared unit
    always_comb
    begin
        mac_a = '0;
        mac_b = '0;
        mac_c = '0;
        case (state_reg)
            ST_XEDGE:
            begin
                mac_a = 16'(cfg.image_width);
                mac_b = 15'(scale);
                mac_c = 26'(cfg.dest_x[11:0]);
            end
            ST_YEDGE:
            begin
                mac_a = 16'(cfg.image_height);
                mac_b = 15'(scale);
                mac_c = 26'(cfg.dest_y[11:0]);
            end
            ST_XPOS:
            begin
                mac_a = 16'(col_reg);
                mac_b = 15'(scale);
                mac_c = 26'(cfg.dest_x[11:0]);
            end
            ST_YPOS:
            begin
                mac_a = 16'(row_reg);
                mac_b = 15'(scale);
                mac_c = 26'(cfg.dest_y[11:0]);
            end
            ST_XOFF:
            begin
                mac_a = off_reg[15:0];
                mac_b = 15'(PIXEL_BYTES);
                mac_c = '0;
            end
            ST_BASE:
            begin
                mac_a = acc_reg[15:0];
                mac_b = cfg.row_pitch;
                mac_c = off_reg;
            end
            ST_WRITE:
            begin
                if (row_end)
                begin
                    mac_a = 16'd1;
                    mac_b = cfg.row_pitch;
                    mac_c = row_base_reg;
                end
                else
                begin
                    mac_a = 16'(PIXEL_BYTES);
                    mac_b = 15'd1;
                    mac_c = off_reg;
                end
            end
            default:
            begin
                mac_a = '0;
                mac_b = '0;
                mac_c = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        col_next          = col_reg;
        row_next          = row_reg;
        color_next        = color_reg;
        acc_next          = acc_reg;
        off_next          = off_reg;
        row_base_next     = row_base_reg;
        sx_next           = sx_reg;
        sy_next           = sy_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && item_ok)
                begin
                    col_next   = pixel.src_col;
                    row_next   = pixel.src_row;
                    color_next = pixel.pixel_color[23:0];
                    state_next = ST_XEDGE;
                end
            end
            ST_XEDGE:
            begin
                acc_next   = mac_y;
                state_next = ST_YEDGE;
            end
            ST_YEDGE:
            begin
                acc_next = mac_y;
                if (acc_reg > 26'(cfg.screen_width))
                    state_next = ST_IDLE;
                else
                    state_next = ST_XPOS;
            end
            ST_XPOS:
            begin
                acc_next = mac_y;
                if (acc_reg > 26'(cfg.screen_height))
                    state_next = ST_IDLE;
                else
                    state_next = ST_YPOS;
            end
            ST_YPOS:
            begin
                // Park x0 in the offset register while y0 forms
                off_next   = acc_reg;
                acc_next   = mac_y;
                state_next = ST_XOFF;
            end
            ST_XOFF:
            begin
                off_next   = mac_y;
                state_next = ST_BASE;
            end
            ST_BASE:
            begin
                off_next      = mac_y;
                row_base_next = mac_y;
                sx_next       = '0;
                sy_next       = '0;
                state_next    = ST_WRITE;
            end
            ST_WRITE:
            begin
                result_valid_next       = 1'b1;
                result_next.byte_offset = off_reg;
                result_next.write_color = color_reg;
                result_next.last_write  = blk_end;
                if (row_end)
                begin
                    // Advance to the next destination row
                    off_next      = mac_y;
                    row_base_next = mac_y;
                    sx_next       = '0;
                    sy_next       = sy_reg + SCALE_W'(1);
                end
                else
                begin
                    off_next = mac_y;
                    sx_next  = sx_reg + SCALE_W'(1);
                end
                if (blk_end)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg      <= col_next;
        row_reg      <= row_next;
        color_reg    <= color_next;
        acc_reg      <= acc_next;
        off_reg      <= off_next;
        row_base_reg <= row_base_next;
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        result_reg   <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

### src/ssb_cfg.sv
// ssb_cfg: APB-style register file holding the blit configuration.
// Depends on ssb_pkg for the register index codes and the config struct.
`default_nettype none

module ssb_cfg (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ssb_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [ssb_pkg::DATA_W-1:0]   pwdata,
    output logic      [ssb_pkg::DATA_W-1:0]   prdata,
    output logic                              pready,
    output ssb_pkg::ssb_cfg_t                 cfg
);

    ssb_pkg::ssb_cfg_t cfg_reg;
    ssb_pkg::ssb_cfg_t cfg_next;
    ssb_pkg::reg_idx_t idx;
    logic              wr_en;

    assign pready = 1'b1;
    assign idx    = ssb_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                ssb_pkg::REG_SCREEN_WIDTH:  cfg_next.screen_width  = pwdata[12:0];
                ssb_pkg::REG_SCREEN_HEIGHT: cfg_next.screen_height = pwdata[12:0];
                ssb_pkg::REG_ROW_PITCH:     cfg_next.row_pitch     = pwdata[14:0];
                ssb_pkg::REG_DEST_X:        cfg_next.dest_x        = pwdata[12:0];
                ssb_pkg::REG_DEST_Y:        cfg_next.dest_y        = pwdata[12:0];
                ssb_pkg::REG_IMAGE_WIDTH:   cfg_next.image_width   = pwdata[12:0];
                ssb_pkg::REG_IMAGE_HEIGHT:  cfg_next.image_height  = pwdata[12:0];
                ssb_pkg::REG_SCALE_FACTOR:  cfg_next.scale_factor  = pwdata[3:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width  <= ssb_pkg::SCREEN_WIDTH_RST;
            cfg_reg.screen_height <= ssb_pkg::SCREEN_HEIGHT_RST;
            cfg_reg.row_pitch     <= ssb_pkg::ROW_PITCH_RST;
            cfg_reg.dest_x        <= '0;
            cfg_reg.dest_y        <= '0;
            cfg_reg.image_width   <= '0;
            cfg_reg.image_height  <= '0;
            cfg_reg.scale_factor  <= ssb_pkg::SCALE_FACTOR_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (idx)
            ssb_pkg::REG_SCREEN_WIDTH:  prdata = 32'(cfg_reg.screen_width);
            ssb_pkg::REG_SCREEN_HEIGHT: prdata = 32'(cfg_reg.screen_height);
            ssb_pkg::REG_ROW_PITCH:     prdata = 32'(cfg_reg.row_pitch);
            ssb_pkg::REG_DEST_X:        prdata = 32'(unsigned'(cfg_reg.dest_x));
            ssb_pkg::REG_DEST_Y:        prdata = 32'(unsigned'(cfg_reg.dest_y));
            ssb_pkg::REG_IMAGE_WIDTH:   prdata = 32'(cfg_reg.image_width);
            ssb_pkg::REG_IMAGE_HEIGHT:  prdata = 32'(cfg_reg.image_height);
            ssb_pkg::REG_SCALE_FACTOR:  prdata = 32'(cfg_reg.scale_factor);
            default:                    prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### src/ssb_mac.sv
// ssb_mac: shared multiply-add unit, y = (a * b + c) mod 2^26.
// Depends on ssb_pkg for the operand widths.
`default_nettype none

module ssb_mac (
    input  wire logic [ssb_pkg::MAC_A_W-1:0] a,
    input  wire logic [ssb_pkg::MAC_B_W-1:0] b,
    input  wire logic [ssb_pkg::MAC_Y_W-1:0] c,
    output logic      [ssb_pkg::MAC_Y_W-1:0] y
);

    logic [ssb_pkg::MAC_A_W+ssb_pkg::MAC_B_W-1:0] prod;

    assign prod = a * b;
    assign y    = prod[ssb_pkg::MAC_Y_W-1:0] + c;

endmodule

`default_nettype wire

### src/ssb_checker.sv
// ssb_checker: port-level assertions on the blit address generator, bound to the top level.
// Depends on ssb_pkg for the result struct.
`default_nettype none

module ssb_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              busy,
    input wire logic              result_valid,
    input wire ssb_pkg::ssb_out_t result
);

    // Writes of one item come in consecutive cycles
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_write |=> result_valid)
        else $error("write burst broken before last write");

    // The block stays busy while writes of an item are still to come
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_write |-> busy)
        else $error("block idle in the middle of a write burst");

    // A burst only starts after the block was working on an item
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(busy))
        else $error("write issued without an item in progress");

    // All writes of one item carry the same color
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_write |=> result.write_color == $past(result.write_color))
        else $error("color changed within one item");

endmodule

bind scaled_sprite_blit_address_gen ssb_checker u_ssb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

`default_nettype wire

### tb/tb_scaled_sprite_blit_address_gen.sv
`timescale 1ns / 100ps
// tb_scaled_sprite_blit_address_gen: self-checking testbench of the scaled sprite blit
// address generator: a directed stimulus table, then random register settings and pixel bursts.
// Depends on ssb_pkg and the RTL under src.

module tb_scaled_sprite_blit_address_gen;

    localparam int PIXEL_BYTES   = ssb_pkg::PIXEL_BYTES_DEF;
    localparam int MAX_SCALE     = ssb_pkg::MAX_SCALE_DEF;
    localparam int ITEM_TARGET   = 220;
    localparam int DRAIN_CYCLES  = 10;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int FROM_MODEL    = -1;

    typedef struct {
        logic              is_reg;
        ssb_pkg::reg_idx_t idx;
        logic [31:0]       wdata;
        ssb_pkg::ssb_in_t  px;
        int                n_writes;
        ssb_pkg::ssb_out_t write;
    } stim_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    ssb_pkg::ssb_in_t              pixel = '0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [ssb_pkg::ADDR_W-1:0]    paddr = '0;
    logic [ssb_pkg::DATA_W-1:0]    pwdata = '0;
    logic                          busy;
    logic                          result_valid;
    ssb_pkg::ssb_out_t             result;
    logic [ssb_pkg::DATA_W-1:0]    prdata;
    logic                          pready;

    ssb_pkg::ssb_cfg_t             blit_cfg;
    ssb_pkg::ssb_out_t             pending_writes[$];
    stim_row_t                     directed_rows[$];
    int                            mismatches = 0;
    int                            cycle_count = 0;
    int                            burst_left = 0;

    scaled_sprite_blit_address_gen u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int effective_scale(input logic [3:0] raw);
        int s;
        s = raw;
        if (s == 0)
            s = 1;
        if (s > MAX_SCALE)
            s = MAX_SCALE;
        return s;
    endfunction

    // Queue the s*s writes that one source pixel causes; return how many.
    function automatic int predict_block_writes(input ssb_pkg::ssb_in_t px);
        int                s;
        int                dx;
        int                dy;
        int                n;
        longint            x0;
        longint            y0;
        longint            off;
        ssb_pkg::ssb_out_t w;
        s  = effective_scale(blit_cfg.scale_factor);
        dx = $signed(blit_cfg.dest_x);
        dy = $signed(blit_cfg.dest_y);
        n  = 0;
        if (dx < 0 || dy < 0)
            return 0;
        if (dx + int'(blit_cfg.image_width) * s > int'(blit_cfg.screen_width))
            return 0;
        if (dy + int'(blit_cfg.image_height) * s > int'(blit_cfg.screen_height))
            return 0;
        if (int'(px.src_col) >= int'(blit_cfg.image_width)
            || int'(px.src_row) >= int'(blit_cfg.image_height))
            return 0;
        if (px.pixel_color == 32'd0)
            return 0;
        x0 = dx + longint'(px.src_col) * s;
        y0 = dy + longint'(px.src_row) * s;
        for (int sy = 0; sy < s; sy++)
        begin
            for (int sx = 0; sx < s; sx++)
            begin
                off = (y0 + sy) * longint'(blit_cfg.row_pitch) + (x0 + sx) * PIXEL_BYTES;
                w.byte_offset = off[25:0];
                w.write_color = px.pixel_color[23:0];
                w.last_write  = (sy == s - 1) && (sx == s - 1);
                pending_writes.push_back(w);
                n++;
            end
        end
        return n;
    endfunction

    function automatic void apply_reg(input ssb_pkg::reg_idx_t idx, input logic [31:0] val);
        case (idx)
            ssb_pkg::REG_SCREEN_WIDTH:  blit_cfg.screen_width  = val[12:0];
            ssb_pkg::REG_SCREEN_HEIGHT: blit_cfg.screen_height = val[12:0];
            ssb_pkg::REG_ROW_PITCH:     blit_cfg.row_pitch     = val[14:0];
            ssb_pkg::REG_DEST_X:        blit_cfg.dest_x        = val[12:0];
            ssb_pkg::REG_DEST_Y:        blit_cfg.dest_y        = val[12:0];
            ssb_pkg::REG_IMAGE_WIDTH:   blit_cfg.image_width   = val[12:0];
            ssb_pkg::REG_IMAGE_HEIGHT:  blit_cfg.image_height  = val[12:0];
            ssb_pkg::REG_SCALE_FACTOR:  blit_cfg.scale_factor  = val[3:0];
            default: ;
        endcase
    endfunction

    function automatic void add_reg(input ssb_pkg::reg_idx_t idx, input logic [31:0] val);
        stim_row_t r;
        r = '{is_reg: 1'b1, idx: idx, wdata: val, px: '0, n_writes: 0, write: '0};
        directed_rows.push_back(r);
    endfunction

    // n_writes of FROM_MODEL leaves the row to the predictor; 1 means one typed write.
    function automatic void add_pixel(input int col, input int row, input logic [31:0] color,
                                      input int n, input int off, input logic [23:0] wcolor);
        stim_row_t r;
        r.is_reg            = 1'b0;
        r.idx               = ssb_pkg::REG_SCREEN_WIDTH;
        r.wdata             = '0;
        r.px.src_col        = col[11:0];
        r.px.src_row        = row[11:0];
        r.px.pixel_color    = color;
        r.n_writes          = n;
        r.write.byte_offset = off[25:0];
        r.write.write_color = wcolor;
        r.write.last_write  = 1'b1;
        directed_rows.push_back(r);
    endfunction

    // Pick an origin and a screen extent that fits an image span of the given size.
    function automatic void place_axis(input int extent, output int origin, output int span);
        int room;
        room = 8191 - extent;
        if (room > 4095)
            room = 4095;
        origin = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(room, 0);
        span   = origin + extent;
        if (span < 8191 && $urandom_range(2, 0) != 0)
            span += $urandom_range(8191 - span, 1);
    endfunction

    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 20)
                                                     : $urandom_range(8, 1);
            gap = $urandom_range(12, 0);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // Hold the pixel and start until the transfer edge.
    task automatic send_pixel(input ssb_pkg::ssb_in_t px);
        pixel <= px;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (busy !== 1'b0 || pending_writes.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input ssb_pkg::reg_idx_t idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        apply_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_phase(inout int sent);
        int               mode;
        int               raw;
        int               s;
        int               iw;
        int               ih;
        int               dx;
        int               dy;
        int               sw;
        int               sh;
        int               col;
        int               row;
        int               items;
        logic [31:0]      color;
        ssb_pkg::ssb_in_t px;
        mode = $urandom_range(9, 0);
        raw  = (mode == 0) ? $urandom_range(1, 0) : $urandom_range(15, 0);
        s    = effective_scale(raw[3:0]);
        if (mode == 0)
        begin
            iw = $urandom_range(4096, 1);
            ih = $urandom_range(4096, 1);
        end
        else
        begin
            iw = $urandom_range(12, 1);
            ih = $urandom_range(12, 1);
        end
        place_axis(iw * s, dx, sw);
        place_axis(ih * s, dy, sh);
        // Break one of the whole-image checks now and then.
        if (mode == 9)
        begin
            case ($urandom_range(3, 0))
                0:       dx = -int'($urandom_range(4096, 1));
                1:       dy = -int'($urandom_range(4096, 1));
                2:       sw = dx + iw * s - 1;
                default: sh = dy + ih * s - 1;
            endcase
        end
        wait_idle();
        write_reg(ssb_pkg::REG_SCREEN_WIDTH, sw);
        write_reg(ssb_pkg::REG_SCREEN_HEIGHT, sh);
        write_reg(ssb_pkg::REG_ROW_PITCH, $urandom_range(32767, 0));
        write_reg(ssb_pkg::REG_DEST_X, dx);
        write_reg(ssb_pkg::REG_DEST_Y, dy);
        write_reg(ssb_pkg::REG_IMAGE_WIDTH, iw);
        write_reg(ssb_pkg::REG_IMAGE_HEIGHT, ih);
        write_reg(ssb_pkg::REG_SCALE_FACTOR, raw);
        items = $urandom_range(35, 15);
        repeat (items)
        begin
            if ($urandom_range(9, 0) == 0)
            begin
                col = $urandom_range(4095, 0);
                row = $urandom_range(4095, 0);
            end
            else
            begin
                col = $urandom_range(iw - 1, 0);
                row = $urandom_range(ih - 1, 0);
            end
            case ($urandom_range(19, 0))
                0, 1:    color = 32'd0;
                2, 3:    color = $urandom_range(255, 1) << 24;
                4:       color = 32'hFFFF_FFFF;
                default: color = $urandom;
            endcase
            px.src_col     = col[11:0];
            px.src_row     = row[11:0];
            px.pixel_color = color;
            pace();
            send_pixel(px);
            void'(predict_block_writes(px));
            sent++;
        end
    endtask

    // Every write must match the oldest one still waiting.
    always @(posedge clk)
    begin
        ssb_pkg::ssb_out_t w;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else if (rst_n && result_valid === 1'b1)
        begin
            if (pending_writes.size() == 0)
            begin
                $error("unexpected write: byte_offset 0x%0h write_color 0x%0h",
                       result.byte_offset, result.write_color);
                mismatches++;
            end
            else
            begin
                w = pending_writes.pop_front();
                if (result.byte_offset !== w.byte_offset)
                begin
                    $error("byte_offset: expected 0x%0h, got 0x%0h",
                           w.byte_offset, result.byte_offset);
                    mismatches++;
                end
                if (result.write_color !== w.write_color)
                begin
                    $error("write_color: expected 0x%0h, got 0x%0h",
                           w.write_color, result.write_color);
                    mismatches++;
                end
                if (result.last_write !== w.last_write)
                begin
                    $error("last_write: expected %0b, got %0b", w.last_write, result.last_write);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        stim_row_t r;
        int        n;
        int        sent;

        // Defaults after reset: 1024x768, pitch 3072, origin 0, empty image, scale 1.
        add_pixel(0, 0, 32'h00FF_FFFF, 0, 0, 24'h0);
        add_reg(ssb_pkg::REG_IMAGE_WIDTH, 4);
        add_reg(ssb_pkg::REG_IMAGE_HEIGHT, 4);
        add_pixel(0, 0, 32'h00FF_FFFF, 1, 0, 24'hFF_FFFF);
        add_pixel(3, 3, 32'h1234_5678, 1, 9225, 24'h34_5678);
        add_pixel(1, 0, 32'hFF00_0000, 1, 3, 24'h00_0000);
        add_pixel(2, 2, 32'h0000_0000, 0, 0, 24'h0);
        add_pixel(4, 0, 32'h0000_0001, 0, 0, 24'h0);
        add_pixel(0, 4, 32'h0000_0001, 0, 0, 24'h0);
        add_pixel(4095, 4095, 32'hFFFF_FFFF, 0, 0, 24'h0);
        add_reg(ssb_pkg::REG_SCALE_FACTOR, 0);
        add_pixel(2, 1, 32'h00AB_CDEF, 1, 3078, 24'hAB_CDEF);
        add_reg(ssb_pkg::REG_SCALE_FACTOR, 2);
        add_pixel(1, 1, 32'h0011_2233, FROM_MODEL, 0, 24'h0);
        // scale above the maximum saturates
        add_reg(ssb_pkg::REG_SCALE_FACTOR, 15);
        add_pixel(3, 3, 32'hFFFF_FFFF, FROM_MODEL, 0, 24'h0);
        add_reg(ssb_pkg::REG_SCALE_FACTOR, 8);
        add_pixel(0, 2, 32'h8000_0000, FROM_MODEL, 0, 24'h0);
        add_reg(ssb_pkg::REG_DEST_X, 32'h1FFF);
        add_pixel(0, 0, 32'h00FF_FFFF, 0, 0, 24'h0);
        add_reg(ssb_pkg::REG_DEST_X, 0);
        add_reg(ssb_pkg::REG_DEST_Y, 32'h1000);
        add_pixel(0, 0, 32'h00FF_FFFF, 0, 0, 24'h0);
        add_reg(ssb_pkg::REG_DEST_Y, 0);
        add_reg(ssb_pkg::REG_SCREEN_WIDTH, 31);
        add_pixel(1, 1, 32'h00FF_FFFF, 0, 0, 24'h0);
        add_reg(ssb_pkg::REG_SCREEN_WIDTH, 32);
        add_pixel(3, 0, 32'h00C0_FFEE, FROM_MODEL, 0, 24'h0);
        add_reg(ssb_pkg::REG_SCREEN_HEIGHT, 31);
        add_pixel(1, 1, 32'h00FF_FFFF, 0, 0, 24'h0);
        // large pitch and bottom origin: offsets wrap
        add_reg(ssb_pkg::REG_SCREEN_HEIGHT, 8191);
        add_reg(ssb_pkg::REG_DEST_Y, 4095);
        add_reg(ssb_pkg::REG_ROW_PITCH, 32767);
        add_pixel(3, 3, 32'h00FE_DCBA, FROM_MODEL, 0, 24'h0);
        add_reg(ssb_pkg::REG_ROW_PITCH, 0);
        add_pixel(2, 3, 32'h0100_0000, FROM_MODEL, 0, 24'h0);
        add_reg(ssb_pkg::REG_SCALE_FACTOR, 1);
        add_reg(ssb_pkg::REG_DEST_Y, 0);
        add_reg(ssb_pkg::REG_SCREEN_WIDTH, 4096);
        add_reg(ssb_pkg::REG_SCREEN_HEIGHT, 4096);
        add_reg(ssb_pkg::REG_IMAGE_WIDTH, 4096);
        add_reg(ssb_pkg::REG_IMAGE_HEIGHT, 4096);
        add_reg(ssb_pkg::REG_ROW_PITCH, 16384);
        add_pixel(4095, 4095, 32'hFFFF_FFFF, FROM_MODEL, 0, 24'h0);
        add_pixel(0, 0, 32'h0000_0001, 1, 0, 24'h00_0001);
        add_reg(ssb_pkg::REG_IMAGE_WIDTH, 1);
        add_reg(ssb_pkg::REG_DEST_X, 4095);
        add_pixel(0, 5, 32'h0055_5555, FROM_MODEL, 0, 24'h0);

        blit_cfg.screen_width  = ssb_pkg::SCREEN_WIDTH_RST;
        blit_cfg.screen_height = ssb_pkg::SCREEN_HEIGHT_RST;
        blit_cfg.row_pitch     = ssb_pkg::ROW_PITCH_RST;
        blit_cfg.dest_x        = '0;
        blit_cfg.dest_y        = '0;
        blit_cfg.image_width   = '0;
        blit_cfg.image_height  = '0;
        blit_cfg.scale_factor  = ssb_pkg::SCALE_FACTOR_RST;
        sent = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            r = directed_rows[i];
            if (r.is_reg)
            begin
                wait_idle();
                write_reg(r.idx, r.wdata);
            end
            else
            begin
                pace();
                send_pixel(r.px);
                if (r.n_writes == FROM_MODEL)
                    n = predict_block_writes(r.px);
                else if (r.n_writes == 1)
                    pending_writes.push_back(r.write);
            end
        end

        while (sent < ITEM_TARGET)
            random_phase(sent);

        wait_idle();
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### scaled_sprite_blit_address_gen.f
src/ssb_pkg.sv
src/ssb_cfg.sv
src/ssb_mac.sv
src/scaled_sprite_blit_address_gen.sv
src/ssb_checker.sv
tb/tb_scaled_sprite_blit_address_gen.sv
